@@ src/asgr_pkg.sv @@
// asgr_pkg: shared types, character codes and sgr code constants for the
// ansi sgr console parser. No dependencies; asgr_sgr_unit and the core import it.
`timescale 1ns / 1ps

package asgr_pkg;

	// default depth of the parameter store
	localparam int MAX_PARAMS_DEF = 16;

	// character codes
	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_SGR   = 8'h6D;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// cursor and parameter limits
	localparam logic [7:0]  POS_MAX = 8'hFF;
	localparam logic [15:0] VAL_MAX = 16'hFFFF;

	// colors
	localparam logic [3:0] FG_DEFAULT = 4'd7;
	localparam logic [3:0] BG_DEFAULT = 4'd0;

	// sgr codes
	localparam logic [15:0] SGR_RESET       = 16'd0;
	localparam logic [15:0] SGR_BOLD        = 16'd1;
	localparam logic [15:0] SGR_REVERSE_ON  = 16'd7;
	localparam logic [15:0] SGR_NORMAL_A    = 16'd21;
	localparam logic [15:0] SGR_NORMAL_B    = 16'd22;
	localparam logic [15:0] SGR_REVERSE_OFF = 16'd27;
	localparam logic [15:0] SGR_FG_FIRST    = 16'd30;
	localparam logic [15:0] SGR_FG_LAST     = 16'd37;
	localparam logic [15:0] SGR_FG_EXT      = 16'd38;
	localparam logic [15:0] SGR_FG_DEFAULT  = 16'd39;
	localparam logic [15:0] SGR_BG_FIRST    = 16'd40;
	localparam logic [15:0] SGR_BG_LAST     = 16'd47;
	localparam logic [15:0] SGR_BG_DEFAULT  = 16'd49;

	// escape parser phase
	typedef enum logic [1:0] {
		PH_TEXT = 2'd0,
		PH_ESC  = 2'd1,
		PH_CSI  = 2'd2,
		PH_FKEY = 2'd3
	} esc_phase_t;

	// sgr walk sequencer
	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_READ,
		SQ_APPLY
	} seq_state_t;

	// text attribute state
	typedef struct packed {
		logic [3:0] fg;
		logic [3:0] bg;
		logic       intense;
		logic       reverse;
	} attr_t;

	// ansi color order to vga color order
	function automatic logic [3:0] ansi_to_vga(input logic [2:0] idx);
		logic [3:0] v;
		case (idx)
			3'd0:    v = 4'd0;
			3'd1:    v = 4'd4;
			3'd2:    v = 4'd2;
			3'd3:    v = 4'd6;
			3'd4:    v = 4'd1;
			3'd5:    v = 4'd5;
			3'd6:    v = 4'd3;
			default: v = 4'd7;
		endcase
		return v;
	endfunction

endpackage

@@ src/asgr_if.sv @@
// asgr_if: valid/ready stream interfaces for the console byte input and the
// character cell output. Depends on nothing.
`timescale 1ns / 1ps

interface asgr_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       escapes_on;

	modport source (output valid, output in_byte, output escapes_on, input ready);
	modport sink   (input valid, input in_byte, input escapes_on, output ready);
endinterface

interface asgr_cell_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] char_code;
	logic [3:0] fg_color;
	logic [3:0] bg_color;
	logic [7:0] col;
	logic [7:0] row;

	modport source (output valid, output kind, output char_code, output fg_color,
		output bg_color, output col, output row, input ready);
	modport sink   (input valid, input kind, input char_code, input fg_color,
		input bg_color, input col, input row, output ready);
endinterface

@@ src/asgr_param_ram.sv @@
// asgr_param_ram: storage for the collected csi parameters, one write port
// and one registered read port. Depends on nothing.
`timescale 1ns / 1ps

module asgr_param_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [15:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [15:0]   rdata
);

	logic [15:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ src/asgr_sgr_unit.sv @@
// asgr_sgr_unit: applies one sgr code to the attribute state; the sequencer
// runs every stored parameter through it. Depends on asgr_pkg.
`timescale 1ns / 1ps

module asgr_sgr_unit (
	input  asgr_pkg::attr_t     attr_cur,
	input  logic [15:0]         code,
	output asgr_pkg::attr_t     attr_nxt
);
	import asgr_pkg::*;

	logic [15:0] fg_off;
	logic [15:0] bg_off;

	assign fg_off = code - SGR_FG_FIRST;
	assign bg_off = code - SGR_BG_FIRST;

	// one sgr code
	always_comb begin
		attr_nxt = attr_cur;
		case (code) inside
			SGR_RESET: begin
				attr_nxt.fg      = FG_DEFAULT;
				attr_nxt.bg      = BG_DEFAULT;
				attr_nxt.intense = 1'b0;
				attr_nxt.reverse = 1'b0;
			end
			SGR_BOLD: begin
				attr_nxt.fg[3]   = 1'b1;
				attr_nxt.intense = 1'b1;
			end
			SGR_NORMAL_A, SGR_NORMAL_B: begin
				attr_nxt.fg[3]   = 1'b0;
				attr_nxt.intense = 1'b0;
			end
			SGR_REVERSE_ON: begin
				if (!attr_cur.reverse) begin
					attr_nxt.fg      = attr_cur.bg;
					attr_nxt.bg      = attr_cur.fg;
					attr_nxt.reverse = 1'b1;
				end
			end
			SGR_REVERSE_OFF: begin
				if (attr_cur.reverse) begin
					attr_nxt.fg      = attr_cur.bg;
					attr_nxt.bg      = attr_cur.fg;
					attr_nxt.reverse = 1'b0;
				end
			end
			[SGR_FG_FIRST:SGR_FG_LAST]: begin
				attr_nxt.fg = ansi_to_vga(fg_off[2:0]) | {attr_cur.intense, 3'b000};
			end
			SGR_FG_EXT, SGR_FG_DEFAULT: begin
				attr_nxt.fg = FG_DEFAULT | {attr_cur.intense, 3'b000};
			end
			[SGR_BG_FIRST:SGR_BG_LAST]: begin
				attr_nxt.bg = ansi_to_vga(bg_off[2:0]);
			end
			SGR_BG_DEFAULT: begin
				attr_nxt.bg = BG_DEFAULT;
			end
			default: begin
			end
		endcase
	end

endmodule

@@ src/ansi_sgr_console_parser_core.sv @@
// ansi_sgr_console_parser_core: top level of the console byte parser.
// Depends on asgr_pkg, asgr_if, asgr_param_ram and asgr_sgr_unit.
`timescale 1ns / 1ps

// Usage
// char_stream (sink) takes one console byte per beat together with
// escapes_on; cell_stream (source) gives one beat per text byte: a character
// to draw or a cursor move, with the current colors and the cursor position
// after the byte. Bytes inside an escape sequence give no beat.
// A text byte's beat is registered and is valid the cycle after it is accepted.
// Any byte but the sgr final 'm' leaves the block free to take the next byte
// straight away unless the output register is stalled. The final 'm' walks
// the stored parameters through the one sgr unit, each with a registered
// store read and then an apply, and the block takes no next byte until all N
// parameters (1 to MAX_PARAMS) have been applied.
// The output register holds a finished beat; while it is full and not taken
// the block takes no byte, and it resumes as soon as the beat is taken.
// Reset (arst_n low) drops any pending beat, returns to plain text, sets
// foreground 7 and background 0 and puts the cursor at column 0, row 0.
// The parameter store is not cleared; each entry is written before it is read.
module ansi_sgr_console_parser_core #(
	parameter int MAX_PARAMS = asgr_pkg::MAX_PARAMS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	asgr_char_if.sink    char_stream,
	asgr_cell_if.source  cell_stream
);
	import asgr_pkg::*;

	localparam int IW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
	localparam int CW = $clog2(MAX_PARAMS + 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PARAMS);

	// parser state
	esc_phase_t    phase_q, phase_d;
	logic          fresh_q, fresh_d;
	logic [CW-1:0] count_q, count_d;
	logic [15:0]   cur_q, cur_d;
	attr_t         attr_q, attr_nxt;
	logic [7:0]    col_q, col_d;
	logic [7:0]    row_q, row_d;

	// sequencer
	seq_state_t    seq_q, seq_d;
	logic [CW-1:0] walk_idx_q;
	logic [CW-1:0] walk_n_q, walk_n_d;
	logic          seq_idle;
	logic          apply_en;

	// decode results
	logic          accept;
	logic [7:0]    b;
	logic          is_digit;
	logic          below_max;
	logic          is_text;
	logic          wr_en;
	logic          start_walk;
	logic [19:0]   acc;
	logic [8:0]    tab_col;
	logic          text_kind;
	logic [7:0]    text_char;
	logic [15:0]   rd_code;

	// output register
	logic          out_valid_q;
	logic          out_kind_q;
	logic [7:0]    out_char_q;
	logic [3:0]    out_fg_q;
	logic [3:0]    out_bg_q;
	logic [7:0]    out_col_q;
	logic [7:0]    out_row_q;

	assign b         = char_stream.in_byte;
	assign accept    = char_stream.valid && char_stream.ready;
	assign is_digit  = (b >= CH_ZERO) && (b <= CH_NINE);
	assign below_max = (count_q < CNT_MAX);
	assign acc       = {1'b0, cur_q, 3'b000} + {3'b000, cur_q, 1'b0}
		+ {12'd0, b - CH_ZERO};

	// escape sequence decode
	always_comb begin
		phase_d    = phase_q;
		fresh_d    = fresh_q;
		count_d    = count_q;
		cur_d      = cur_q;
		wr_en      = 1'b0;
		start_walk = 1'b0;
		is_text    = 1'b0;
		walk_n_d   = below_max ? count_q + CW'(1) : CNT_MAX;
		if (char_stream.escapes_on) begin
			unique case (phase_q)
				PH_CSI: begin
					fresh_d = 1'b0;
					if (is_digit) begin
						if (below_max) begin
							cur_d = (|acc[19:16]) ? VAL_MAX : acc[15:0];
						end
					end else if (b == CH_SEMI) begin
						if (below_max) begin
							wr_en   = 1'b1;
							count_d = count_q + CW'(1);
							cur_d   = '0;
						end
					end else if (b == CH_LBRK && fresh_q) begin
						phase_d = PH_FKEY;
					end else begin
						if (b == CH_SGR) begin
							wr_en      = below_max;
							start_walk = 1'b1;
						end
						phase_d = PH_TEXT;
					end
				end
				PH_FKEY: begin
					phase_d = PH_TEXT;
				end
				PH_ESC: begin
					if (b == CH_LBRK) begin
						phase_d = PH_CSI;
						count_d = '0;
						cur_d   = '0;
						fresh_d = 1'b1;
					end else if (b == CH_ESC) begin
						phase_d = PH_ESC;
					end else begin
						phase_d = PH_TEXT;
						is_text = 1'b1;
					end
				end
				PH_TEXT: begin
					if (b == CH_ESC) begin
						phase_d = PH_ESC;
					end else begin
						is_text = 1'b1;
					end
				end
			endcase
		end else begin
			is_text = 1'b1;
		end
	end

	// cursor update for text bytes
	assign tab_col = {1'b0, col_q[7:3], 3'b000} + 9'd8;

	always_comb begin
		col_d     = col_q;
		row_d     = row_q;
		text_kind = 1'b0;
		text_char = b;
		if (b == CH_NL) begin
			col_d     = '0;
			row_d     = (row_q != POS_MAX) ? row_q + 8'd1 : row_q;
			text_kind = 1'b1;
			text_char = '0;
		end else if (b == CH_TAB) begin
			col_d     = tab_col[8] ? POS_MAX : tab_col[7:0];
			text_kind = 1'b1;
			text_char = '0;
		end else begin
			col_d = (col_q != POS_MAX) ? col_q + 8'd1 : col_q;
		end
	end

	// sequencer next state
	always_comb begin
		seq_d = seq_q;
		unique case (seq_q)
			SQ_IDLE: begin
				if (accept && start_walk) begin
					seq_d = SQ_READ;
				end
			end
			SQ_READ: begin
				seq_d = SQ_APPLY;
			end
			SQ_APPLY: begin
				if (walk_idx_q + CW'(1) == walk_n_q) begin
					seq_d = SQ_IDLE;
				end else begin
					seq_d = SQ_READ;
				end
			end
			default: begin
				seq_d = SQ_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		seq_idle = 1'b0;
		apply_en = 1'b0;
		unique case (seq_q)
			SQ_IDLE:  seq_idle = 1'b1;
			SQ_READ:  seq_idle = 1'b0;
			SQ_APPLY: apply_en = 1'b1;
			default:  seq_idle = 1'b0;
		endcase
	end

	assign char_stream.ready = seq_idle && (!out_valid_q || cell_stream.ready);

	// parameter store
	asgr_param_ram #(
		.DEPTH (MAX_PARAMS),
		.AW    (IW)
	) u_ram (
		.clk   (clk),
		.we    (accept && wr_en),
		.waddr (count_q[IW-1:0]),
		.wdata (cur_q),
		.raddr (walk_idx_q[IW-1:0]),
		.rdata (rd_code)
	);

	// shared sgr unit
	asgr_sgr_unit u_sgr (
		.attr_cur (attr_q),
		.code     (rd_code),
		.attr_nxt (attr_nxt)
	);

	// control and attribute state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_TEXT;
			fresh_q    <= 1'b0;
			count_q    <= '0;
			seq_q      <= SQ_IDLE;
			walk_idx_q <= '0;
			walk_n_q   <= '0;
			attr_q     <= '{fg: FG_DEFAULT, bg: BG_DEFAULT, intense: 1'b0, reverse: 1'b0};
			col_q      <= '0;
			row_q      <= '0;
		end else begin
			seq_q <= seq_d;
			if (accept) begin
				phase_q <= phase_d;
				fresh_q <= fresh_d;
				count_q <= count_d;
				if (start_walk) begin
					walk_idx_q <= '0;
					walk_n_q   <= walk_n_d;
				end
				if (is_text) begin
					col_q <= col_d;
					row_q <= row_d;
				end
			end
			if (apply_en) begin
				attr_q     <= attr_nxt;
				walk_idx_q <= walk_idx_q + CW'(1);
			end
		end
	end

	// parameter accumulator
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q <= cur_d;
		end
	end

	// output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && is_text) begin
			out_valid_q <= 1'b1;
		end else if (cell_stream.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output beat payload
	always_ff @(posedge clk) begin
		if (accept && is_text) begin
			out_kind_q <= text_kind;
			out_char_q <= text_char;
			out_fg_q   <= attr_q.fg;
			out_bg_q   <= attr_q.bg;
			out_col_q  <= col_d;
			out_row_q  <= row_d;
		end
	end

	assign cell_stream.valid     = out_valid_q;
	assign cell_stream.kind      = out_kind_q;
	assign cell_stream.char_code = out_char_q;
	assign cell_stream.fg_color  = out_fg_q;
	assign cell_stream.bg_color  = out_bg_q;
	assign cell_stream.col       = out_col_q;
	assign cell_stream.row       = out_row_q;

endmodule

@@ src/asgr_checker.sv @@
// asgr_checker: port-level checks on the console parser top level, with the
// bind that attaches them. Depends on ansi_sgr_console_parser_core.
`timescale 1ns / 1ps

module asgr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       kind,
	input logic [7:0] char_code,
	input logic [3:0] fg_color,
	input logic [3:0] bg_color,
	input logic [7:0] col,
	input logic [7:0] row
);

	// a stalled beat holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(char_code)
			&& $stable(fg_color) && $stable(bg_color) && $stable(col) && $stable(row))
		else $error("stalled output beat changed");

	// no byte taken while a finished beat is stuck
	a_no_take_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("byte taken while output stalled");

	// cursor moves carry no character
	a_move_no_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind |-> char_code == 8'd0)
		else $error("cursor move beat with nonzero character");

	// a new beat follows an accepted byte
	a_beat_has_byte: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid ##1 out_valid |-> $past(in_valid && in_ready))
		else $error("output beat without an accepted byte");

endmodule

bind ansi_sgr_console_parser_core asgr_checker u_asgr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (char_stream.valid),
	.in_ready  (char_stream.ready),
	.out_valid (cell_stream.valid),
	.out_ready (cell_stream.ready),
	.kind      (cell_stream.kind),
	.char_code (cell_stream.char_code),
	.fg_color  (cell_stream.fg_color),
	.bg_color  (cell_stream.bg_color),
	.col       (cell_stream.col),
	.row       (cell_stream.row)
);
